/* design/ripq_pkg.sv */
// Package for the read-index pending queue.
// Request and result codes, plus the command/status structs between the
// controller and the datapath. No dependencies.
package ripq_pkg;

    // Request modes
    localparam logic [1:0] MODE_ADD = 2'd0;
    localparam logic [1:0] MODE_ACK = 2'd1;
    localparam logic [1:0] MODE_ADV = 2'd2;
    localparam logic [1:0] MODE_NOP = 2'd3;

    // Result kinds
    localparam logic [1:0] KIND_ADD  = 2'd0;
    localparam logic [1:0] KIND_ACK  = 2'd1;
    localparam logic [1:0] KIND_REL  = 2'd2;
    localparam logic [1:0] KIND_MISS = 2'd3;

    // Add status codes
    localparam logic [1:0] ADD_OK   = 2'd0;
    localparam logic [1:0] ADD_DUP  = 2'd1;
    localparam logic [1:0] ADD_FULL = 2'd2;

    // Controller to datapath commands
    typedef struct packed {
        logic latch;       // capture the input beat, restart the scan
        logic rd_scan;     // read the entry at the scan position
        logic pos_inc;     // step the scan position
        logic hit;         // key found at scan position
        logic do_add;      // append the request (or flag full)
        logic do_ack;      // set the peer bit and count acks
        logic rd_rel;      // read the entry at the release position
        logic rel_inc;     // step the release position
        logic rel_done;    // retire released entries
        logic load_reply;  // load a single reply beat
        logic load_rel;    // load a released-entry beat
    } ctrl_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic [1:0] in_mode;   // mode on the input port
        logic [1:0] mode;      // mode of the request in work
        logic       empty;
        logic       hit;       // read key equals request key
        logic       scan_last; // scan position is the tail
        logic       rel_last;  // release position is the matched entry
        logic       out_free;  // output register can take a beat
    } dp_status_t;

endpackage

/* design/ripq_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ripq_ram #(
    parameter int WIDTH = 144,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* design/ripq_ctrl.sv */
// Controller state machine for the read-index pending queue.
// Depends on ripq_pkg for command and status structs and codes.
module ripq_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  ripq_pkg::dp_status_t   status,
    output ripq_pkg::ctrl_cmd_t    cmd
);
    import ripq_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE    = 8'b0000_0001,
        S_READ    = 8'b0000_0010,
        S_CMP     = 8'b0000_0100,
        S_MISS    = 8'b0000_1000,
        S_ACK     = 8'b0001_0000,
        S_REPLY   = 8'b0010_0000,
        S_REL_RD  = 8'b0100_0000,
        S_REL_OUT = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.latch = 1'b1;
                    if (status.in_mode == MODE_NOP)
                    begin
                        state_next = S_IDLE;
                    end
                    else if (status.empty)
                    begin
                        state_next = S_MISS;
                    end
                    else
                    begin
                        state_next = S_READ;
                    end
                end
            end
            S_READ:
            begin
                cmd.rd_scan = 1'b1;
                state_next  = S_CMP;
            end
            S_CMP:
            begin
                if (status.hit)
                begin
                    cmd.hit = 1'b1;
                    unique case (status.mode)
                        MODE_ACK: state_next = S_ACK;
                        MODE_ADV: state_next = S_REL_RD;
                        default:  state_next = S_REPLY;
                    endcase
                end
                else if (status.scan_last)
                begin
                    state_next = S_MISS;
                end
                else
                begin
                    cmd.pos_inc = 1'b1;
                    state_next  = S_READ;
                end
            end
            S_MISS:
            begin
                cmd.do_add = (status.mode == MODE_ADD);
                state_next = S_REPLY;
            end
            S_ACK:
            begin
                cmd.do_ack = 1'b1;
                state_next = S_REPLY;
            end
            S_REPLY:
            begin
                if (status.out_free)
                begin
                    cmd.load_reply = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_REL_RD:
            begin
                cmd.rd_rel = 1'b1;
                state_next = S_REL_OUT;
            end
            S_REL_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.load_rel = 1'b1;
                    if (status.rel_last)
                    begin
                        cmd.rel_done = 1'b1;
                        state_next   = S_IDLE;
                    end
                    else
                    begin
                        cmd.rel_inc = 1'b1;
                        state_next  = S_REL_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

/* design/ripq_datapath.sv */
// Datapath for the read-index pending queue: entry RAM, ring pointers,
// scan and release counters, ack counting and the output register.
// Depends on ripq_pkg and ripq_ram.
module ripq_datapath #(
    parameter int QUEUE_DEPTH = 16,
    parameter int PEER_COUNT  = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [1:0]           mode,
    input  logic [63:0]          req_key,
    input  logic [63:0]          commit_index,
    input  logic [3:0]           peer_id,
    input  ripq_pkg::ctrl_cmd_t  cmd,
    output ripq_pkg::dp_status_t status,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [1:0]           kind,
    output logic [1:0]           add_status,
    output logic [4:0]           ack_count,
    output logic [63:0]          released_key,
    output logic [63:0]          released_index,
    output logic                 last,
    output logic [63:0]          newest_key,
    output logic                 newest_valid
);
    import ripq_pkg::*;

    localparam int PW     = $clog2(QUEUE_DEPTH);
    localparam int CNTW   = $clog2(QUEUE_DEPTH + 1);
    localparam int WORD_W = 128 + PEER_COUNT;
    localparam int PCW    = $clog2(PEER_COUNT + 2);

    // Request in work
    logic [1:0]           mode_reg;
    logic [63:0]          key_reg;
    logic [63:0]          cidx_reg;
    logic [3:0]           peer_reg;
    // Queue state
    logic [PW-1:0]        head_reg;
    logic [CNTW-1:0]      count_reg;
    logic [63:0]          newest_key_reg;
    // Scan and release
    logic [PW-1:0]        pos_reg;
    logic [PW-1:0]        match_pos_reg;
    logic [PW-1:0]        rel_reg;
    logic [1:0]           add_status_reg;
    logic [4:0]           ack_count_reg;
    // Output register
    logic                 out_valid_reg;
    logic [1:0]           kind_reg;
    logic [1:0]           add_status_out_reg;
    logic [4:0]           ack_count_out_reg;
    logic [63:0]          released_key_reg;
    logic [63:0]          released_index_reg;
    logic                 last_reg;
    logic [63:0]          newest_key_out_reg;
    logic                 newest_valid_reg;

    logic [WORD_W-1:0]     rd_data;
    logic [63:0]           rd_key;
    logic [63:0]           rd_idx;
    logic [PEER_COUNT-1:0] rd_acks;
    logic [PEER_COUNT-1:0] acks_new;
    logic [PCW-1:0]        ack_total;
    logic                  full;
    logic                  ram_we;
    logic [PW-1:0]         ram_waddr;
    logic [WORD_W-1:0]     ram_wdata;
    logic                  ram_re;
    logic [PW-1:0]         ram_raddr;
    logic [PW:0]           n_rel;
    logic                  rel_nonempty;

    // Ring slot of an offset from the head
    function automatic logic [PW-1:0] ring_slot(input logic [PW-1:0] head,
                                                input logic [PW:0]   off);
        logic [PW:0] sum;
        sum = {1'b0, head} + off;
        if (sum >= (PW+1)'(QUEUE_DEPTH))
        begin
            sum = sum - (PW+1)'(QUEUE_DEPTH);
        end
        return sum[PW-1:0];
    endfunction

    // Number of set bits, plus the local node
    function automatic logic [PCW-1:0] ack_sum(input logic [PEER_COUNT-1:0] v);
        logic [PCW-1:0] n;
        n = PCW'(1);
        for (int i = 0; i < PEER_COUNT; i++)
        begin
            n = n + PCW'(v[i]);
        end
        return n;
    endfunction

    assign rd_key  = rd_data[63:0];
    assign rd_idx  = rd_data[127:64];
    assign rd_acks = rd_data[WORD_W-1:128];
    assign full    = (count_reg == CNTW'(QUEUE_DEPTH));

    // Peer bit set, out-of-range peers set nothing
    always_comb
    begin
        acks_new = rd_acks;
        if (32'(peer_reg) < PEER_COUNT)
        begin
            acks_new = rd_acks | (PEER_COUNT'(1) << peer_reg);
        end
    end
    assign ack_total = ack_sum(acks_new);

    // Entry RAM ports
    assign ram_re    = cmd.rd_scan | cmd.rd_rel;
    assign ram_raddr = ring_slot(head_reg, {1'b0, cmd.rd_rel ? rel_reg : pos_reg});
    assign ram_we    = cmd.do_ack | (cmd.do_add & ~full);
    assign ram_waddr = cmd.do_ack ? ring_slot(head_reg, {1'b0, pos_reg})
                                  : ring_slot(head_reg, (PW+1)'(count_reg));
    assign ram_wdata = cmd.do_ack ? {acks_new, rd_idx, rd_key}
                                  : {{PEER_COUNT{1'b0}}, cidx_reg, key_reg};

    ripq_ram #(
        .WIDTH (WORD_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (rd_data)
    );

    // Released entry count, and whether entries remain after the release
    assign n_rel        = {1'b0, match_pos_reg} + (PW+1)'(1);
    assign rel_nonempty = (CNTW'(n_rel) != count_reg);

    // Request capture and scan bookkeeping
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            mode_reg       <= mode;
            key_reg        <= req_key;
            cidx_reg       <= commit_index;
            peer_reg       <= peer_id;
            pos_reg        <= '0;
            add_status_reg <= ADD_OK;
            ack_count_reg  <= '0;
        end
        if (cmd.pos_inc)
        begin
            pos_reg <= pos_reg + PW'(1);
        end
        if (cmd.hit)
        begin
            match_pos_reg  <= pos_reg;
            rel_reg        <= '0;
            add_status_reg <= ADD_DUP;
        end
        if (cmd.do_add)
        begin
            add_status_reg <= full ? ADD_FULL : ADD_OK;
        end
        if (cmd.do_ack)
        begin
            ack_count_reg <= 5'(ack_total);
        end
        if (cmd.rel_inc)
        begin
            rel_reg <= rel_reg + PW'(1);
        end
    end

    // Queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg       <= '0;
            count_reg      <= '0;
            newest_key_reg <= '0;
        end
        else if (cmd.do_add && !full)
        begin
            count_reg      <= count_reg + CNTW'(1);
            newest_key_reg <= key_reg;
        end
        else if (cmd.rel_done)
        begin
            head_reg  <= ring_slot(head_reg, n_rel);
            count_reg <= count_reg - CNTW'(n_rel);
        end
    end

    // Output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_reply || cmd.load_rel)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output beat payload
    always_ff @(posedge clk)
    begin
        if (cmd.load_reply)
        begin
            case (mode_reg)
                MODE_ADD: kind_reg <= KIND_ADD;
                MODE_ACK: kind_reg <= KIND_ACK;
                default:  kind_reg <= KIND_MISS;
            endcase
            add_status_out_reg <= (mode_reg == MODE_ADD) ? add_status_reg : 2'd0;
            ack_count_out_reg  <= (mode_reg == MODE_ACK) ? ack_count_reg : 5'd0;
            released_key_reg   <= '0;
            released_index_reg <= '0;
            last_reg           <= 1'b1;
            newest_valid_reg   <= (count_reg != '0);
            newest_key_out_reg <= (count_reg != '0) ? newest_key_reg : 64'd0;
        end
        else if (cmd.load_rel)
        begin
            kind_reg           <= KIND_REL;
            add_status_out_reg <= 2'd0;
            ack_count_out_reg  <= 5'd0;
            released_key_reg   <= rd_key;
            released_index_reg <= rd_idx;
            last_reg           <= status.rel_last;
            newest_valid_reg   <= rel_nonempty;
            newest_key_out_reg <= rel_nonempty ? newest_key_reg : 64'd0;
        end
    end

    // Status to the controller
    assign status.in_mode   = mode;
    assign status.mode      = mode_reg;
    assign status.empty     = (count_reg == '0);
    assign status.hit       = (rd_key == key_reg);
    assign status.scan_last = ((CNTW'(pos_reg) + CNTW'(1)) == count_reg);
    assign status.rel_last  = (rel_reg == match_pos_reg);
    assign status.out_free  = ~out_valid_reg | out_ready;

    assign out_valid      = out_valid_reg;
    assign kind           = kind_reg;
    assign add_status     = add_status_out_reg;
    assign ack_count      = ack_count_out_reg;
    assign released_key   = released_key_reg;
    assign released_index = released_index_reg;
    assign last           = last_reg;
    assign newest_key     = newest_key_out_reg;
    assign newest_valid   = newest_valid_reg;

endmodule

/* design/read_index_pending_queue.sv */
// Read-index pending queue: an ordered ring of up to QUEUE_DEPTH requests
// (key, commit index, peer ack bitmap) held in one RAM with registered read.
// Requests are handled one at a time; the key search walks the live entries
// from the head with a RAM read, then a compare, for each entry; a reply
// beat may then wait on out_ready. An advance that matches an entry then
// releases the entries from the head through the match, each read from the
// RAM and loaded as a beat, head first, with last set on the matched entry.
// Mode 3 is taken and dropped without starting work. in_ready is high only
// between requests; a finished beat sits in the output register while the
// next request is taken. Entries are not cleared at reset; of the queue
// state only the head pointer, fill count and newest key are.
// Depends on ripq_pkg, ripq_ctrl, ripq_datapath and ripq_ram.
module read_index_pending_queue #(
    parameter int QUEUE_DEPTH = 16,
    parameter int PEER_COUNT  = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  mode,
    input  logic [63:0] req_key,
    input  logic [63:0] commit_index,
    input  logic [3:0]  peer_id,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  kind,
    output logic [1:0]  add_status,
    output logic [4:0]  ack_count,
    output logic [63:0] released_key,
    output logic [63:0] released_index,
    output logic        last,
    output logic [63:0] newest_key,
    output logic        newest_valid
);
    import ripq_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    ripq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    ripq_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .PEER_COUNT  (PEER_COUNT)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .mode           (mode),
        .req_key        (req_key),
        .commit_index   (commit_index),
        .peer_id        (peer_id),
        .cmd            (cmd),
        .status         (status),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .kind           (kind),
        .add_status     (add_status),
        .ack_count      (ack_count),
        .released_key   (released_key),
        .released_index (released_index),
        .last           (last),
        .newest_key     (newest_key),
        .newest_valid   (newest_valid)
    );

    // An accepted add always leaves the queue nonempty
    a_add_newest: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_ADD && add_status == ADD_OK |-> newest_valid)
        else $error("accepted add reported an empty queue");

    // Single-beat replies always close their request
    a_reply_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == KIND_ADD || kind == KIND_ACK || kind == KIND_MISS)
        |-> last)
        else $error("single reply beat without last");

    // Unused mode is dropped without starting work
    a_nop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && mode == MODE_NOP |=> in_ready)
        else $error("unused mode started a search");

    // No new beat is loaded over one that is stalled
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !cmd.load_reply && !cmd.load_rel)
        else $error("output beat overwritten while stalled");

endmodule
